// ----- design/mpq_pkg.sv -----
// Shared types, constants and the entry ordering function of the priority queue.
`timescale 1ns / 1ps
`default_nettype none
package mpq_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = ADDR_W + 2;
  localparam int KEY_W    = 16;
  localparam int PAY_W    = 32;
  localparam int AGE_W    = 32;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    opcode_t            cmd;
    logic [KEY_W-1:0]   key;
    logic [PAY_W-1:0]   payload;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic               removed_valid;
    logic [KEY_W-1:0]   removed_key;
    logic [PAY_W-1:0]   removed_payload;
    logic [CNT_W-1:0]   occupancy;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [PAY_W-1:0]   payload;
    logic [AGE_W-1:0]   age;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_RM_RD,
    S_DN_RD,
    S_DN_CMP,
    S_EMIT
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic rd_root;
    logic rd_parent;
    logic rd_children;
    logic take_root;
    logic up_move;
    logic dn_move;
    logic put_carried;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic empty;
    logic full;
    logic hole_zero;
    logic up_win;
    logic dn_leaf;
    logic dn_win;
  } dp_status_t;

  // True when entry a ranks strictly above entry b: larger key, or the older of equal keys
  function automatic logic ranks_above(entry_t a, entry_t b);
    logic [AGE_W-1:0] d;
    d = b.age - a.age;
    if (a.key != b.key) begin
      return a.key > b.key;
    end
    return (d != '0) && !d[AGE_W-1];
  endfunction

endpackage
`default_nettype wire

// ----- design/mpq_dpath.sv -----
// Heap memory, sift registers, occupancy and result registers of the priority queue.
`timescale 1ns / 1ps
`default_nettype none
module mpq_dpath import mpq_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire in_item_t   in_item,
  input  wire ctrl_cmd_t  cmd,
  output dp_status_t      st,
  output out_item_t       out_item
);

  entry_t mem [CAPACITY];

  entry_t            rd_a_r, rd_b_r;
  entry_t            carried_r, carried_nxt;
  logic [ADDR_W-1:0] hole_r, hole_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [AGE_W-1:0]  seq_r, seq_nxt;
  status_t           status_r, status_nxt;
  logic              rvalid_r, rvalid_nxt;
  logic [KEY_W-1:0]  rkey_r, rkey_nxt;
  logic [PAY_W-1:0]  rpay_r, rpay_nxt;
  out_item_t         out_r;

  logic [ADDR_W-1:0] hole_m1, parent_idx;
  logic [IDX_W-1:0]  left_idx, right_idx, count_ext;
  logic              left_in, right_in, l_beats, r_beats_c, r_beats_l, pick_right;
  logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
  logic              we;
  entry_t            wdata;

  assign hole_m1    = hole_r - ADDR_W'(1);
  assign parent_idx = {1'b0, hole_m1[ADDR_W-1:1]};
  assign left_idx   = {1'b0, hole_r, 1'b1};
  assign right_idx  = left_idx + IDX_W'(1);
  assign count_ext  = IDX_W'(count_r);
  assign left_in    = left_idx < count_ext;
  assign right_in   = right_idx < count_ext;

  // Pick the best of carried entry, left child and right child
  assign l_beats    = left_in && ranks_above(rd_a_r, carried_r);
  assign r_beats_c  = right_in && ranks_above(rd_b_r, carried_r);
  assign r_beats_l  = right_in && ranks_above(rd_b_r, rd_a_r);
  assign pick_right = l_beats ? r_beats_l : r_beats_c;

  assign st.empty     = count_r == '0;
  assign st.full      = count_r == CNT_W'(CAPACITY);
  assign st.hole_zero = hole_r == '0;
  assign st.up_win    = ranks_above(carried_r, rd_a_r);
  assign st.dn_leaf   = !left_in;
  assign st.dn_win    = l_beats || r_beats_c;

  always_comb begin
    rd_addr_a = '0;
    rd_addr_b = '0;
    if (cmd.rd_root) begin
      rd_addr_a = '0;
      rd_addr_b = ADDR_W'(count_r - CNT_W'(1));
    end else if (cmd.rd_parent) begin
      rd_addr_a = parent_idx;
    end else if (cmd.rd_children) begin
      rd_addr_a = left_idx[ADDR_W-1:0];
      rd_addr_b = right_idx[ADDR_W-1:0];
    end
  end

  always_comb begin
    we    = cmd.up_move || cmd.dn_move || cmd.put_carried;
    wdata = carried_r;
    if (cmd.up_move) begin
      wdata = rd_a_r;
    end else if (cmd.dn_move) begin
      wdata = pick_right ? rd_b_r : rd_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[hole_r] <= wdata;
    end
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  always_comb begin
    carried_nxt = carried_r;
    hole_nxt    = hole_r;
    count_nxt   = count_r;
    seq_nxt     = seq_r;
    status_nxt  = status_r;
    rvalid_nxt  = rvalid_r;
    rkey_nxt    = rkey_r;
    rpay_nxt    = rpay_r;
    if (cmd.accept) begin
      status_nxt = ST_OK;
      rvalid_nxt = 1'b0;
      rkey_nxt   = '0;
      rpay_nxt   = '0;
      if (in_item.cmd == OP_INSERT) begin
        if (st.full) begin
          status_nxt = ST_FULL;
        end else begin
          carried_nxt = '{key: in_item.key, payload: in_item.payload, age: seq_r};
          hole_nxt    = ADDR_W'(count_r);
          count_nxt   = count_r + CNT_W'(1);
          seq_nxt     = seq_r + AGE_W'(1);
        end
      end else if (st.empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        rvalid_nxt = 1'b1;
        count_nxt  = count_r - CNT_W'(1);
      end
    end
    if (cmd.take_root) begin
      rkey_nxt    = rd_a_r.key;
      rpay_nxt    = rd_a_r.payload;
      carried_nxt = rd_b_r;
      hole_nxt    = '0;
    end
    if (cmd.up_move) begin
      hole_nxt = parent_idx;
    end
    if (cmd.dn_move) begin
      hole_nxt = pick_right ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      seq_r   <= '0;
    end else begin
      count_r <= count_nxt;
      seq_r   <= seq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    carried_r <= carried_nxt;
    hole_r    <= hole_nxt;
    status_r  <= status_nxt;
    rvalid_r  <= rvalid_nxt;
    rkey_r    <= rkey_nxt;
    rpay_r    <= rpay_nxt;
    if (cmd.load_out) begin
      out_r <= '{status: status_r, removed_valid: rvalid_r, removed_key: rkey_r,
                 removed_payload: rpay_r, occupancy: count_r};
    end
  end

  assign out_item = out_r;

endmodule
`default_nettype wire

// ----- design/mpq_ctrl.sv -----
// Sequencing state machine and output handshake of the priority queue.
`timescale 1ns / 1ps
`default_nettype none
module mpq_ctrl import mpq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire opcode_t     in_cmd,
  output logic             in_stall,
  output logic             out_valid,
  input  wire logic        out_stall,
  output ctrl_cmd_t        cmd,
  input  wire dp_status_t  st
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_cmd == OP_INSERT) begin
            state_nxt = st.full ? S_EMIT : S_UP_CHK;
          end else if (st.empty) begin
            state_nxt = S_EMIT;
          end else begin
            cmd.rd_root = 1'b1;
            state_nxt   = S_RM_RD;
          end
        end
      end
      S_UP_CHK: begin
        if (st.hole_zero) begin
          cmd.put_carried = 1'b1;
          state_nxt       = S_EMIT;
        end else begin
          cmd.rd_parent = 1'b1;
          state_nxt     = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (st.up_win) begin
          cmd.up_move = 1'b1;
          state_nxt   = S_UP_CHK;
        end else begin
          cmd.put_carried = 1'b1;
          state_nxt       = S_EMIT;
        end
      end
      S_RM_RD: begin
        // Occupancy is already decremented: empty here means the root was the last entry
        cmd.take_root = 1'b1;
        state_nxt     = st.empty ? S_EMIT : S_DN_RD;
      end
      S_DN_RD: begin
        if (st.dn_leaf) begin
          cmd.put_carried = 1'b1;
          state_nxt       = S_EMIT;
        end else begin
          cmd.rd_children = 1'b1;
          state_nxt       = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (st.dn_win) begin
          cmd.dn_move = 1'b1;
          state_nxt   = S_DN_RD;
        end else begin
          cmd.put_carried = 1'b1;
          state_nxt       = S_EMIT;
        end
      end
      S_EMIT: begin
        // Hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.load_out || (out_valid_r && out_stall);
  assign out_valid     = out_valid_r;
  assign in_stall      = state_r != S_IDLE;

  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result appeared without passing through emit");

  a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_valid_r && out_stall) |=> (state_r == S_EMIT))
    else $error("emit left while output register busy");

  a_refused_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && in_cmd == OP_INSERT && st.full)
    |=> (state_r == S_EMIT))
    else $error("insert into full queue did not go straight to emit");

  a_root_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RM_RD) |-> $past(state_r == S_IDLE && in_valid))
    else $error("root read without an accepted remove");

endmodule
`default_nettype wire

// ----- design/max_priority_queue.sv -----
// Top level of the max priority queue: controller plus heap datapath.
`timescale 1ns / 1ps
`default_nettype none
// Max priority queue of up to CAPACITY (256) entries, each a 16-bit key and a 32-bit
// payload, kept as a binary heap in a two-read, one-write memory. An insert puts the
// entry at the end and sifts it up; a remove returns the root and sifts the last entry
// down. Among equal keys the entry inserted first leaves first. Every item gives one
// result with status and occupancy. One item is worked at a time: each sift level is a
// registered memory read, then a compare and write. The longest item at this capacity
// is an insert of the last free slot that climbs all eight levels; a refused insert or
// a remove from an empty queue goes straight to its result. The next item is taken as
// soon as the previous result is in the output register, whether or not it has been
// collected.
module max_priority_queue import mpq_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  ctrl_cmd_t  cmd;
  dp_status_t st;

  mpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_item.cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .st        (st)
  );

  mpq_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .st       (st),
    .out_item (out_item)
  );

endmodule
`default_nettype wire
